[hdl/assert_macros.svh]
// Assertion macros for concurrent checks, included by the cipher unit top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk and disabled while reset is held.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, sampled on clk and disabled while reset is held.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

[hdl/aes128_pkg.sv]
// Package with the AES-128 constants, tables, round functions and control types.
package aes128_pkg;

  localparam int NR       = 10;
  localparam int NROWS    = NR + 1;
  localparam int RA_W     = $clog2(NROWS);
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W    = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_HIGH = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_KEY_LOW  = 1'b1;

  localparam logic CMD_DECRYPT = 1'b1;

  typedef enum logic [2:0] {
    ST_EXP_LOAD,
    ST_EXPAND,
    ST_IDLE,
    ST_ADD,
    ST_ROUND
  } ctl_state_t;

  typedef struct packed {
    logic            exp_load;
    logic            exp_step;
    logic [RA_W-1:0] exp_addr;
    logic            accept;
    logic            add_key;
    logic            do_round;
    logic            last;
    logic            load_result;
    logic [RA_W-1:0] rd_addr;
  } dp_cmd_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
  };

  localparam logic [7:0] INV_SBOX [256] = '{
    8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
    8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
    8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
    8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
    8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
    8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
    8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
    8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
    8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
    8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
    8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
    8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
    8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
    8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
    8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
    8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
  };

  function automatic logic [7:0] xtime(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  // One column through MixColumns, or through InvMixColumns when inv is set.
  function automatic logic [31:0] mix_col(input logic [31:0] w, input logic inv);
    logic [7:0] a [4];
    logic [7:0] x2 [4];
    logic [7:0] x4 [4];
    logic [7:0] x8 [4];
    logic [7:0] m2 [4];
    logic [7:0] m3 [4];
    logic [7:0] m9 [4];
    logic [7:0] mb [4];
    logic [7:0] md [4];
    logic [7:0] me [4];
    logic [31:0] res;
    for (int k = 0; k < 4; k++) begin
      a[k]  = w[31-8*k -: 8];
      x2[k] = xtime(a[k]);
      x4[k] = xtime(x2[k]);
      x8[k] = xtime(x4[k]);
      m2[k] = x2[k];
      m3[k] = x2[k] ^ a[k];
      m9[k] = x8[k] ^ a[k];
      mb[k] = x8[k] ^ x2[k] ^ a[k];
      md[k] = x8[k] ^ x4[k] ^ a[k];
      me[k] = x8[k] ^ x4[k] ^ x2[k];
    end
    for (int r = 0; r < 4; r++) begin
      if (inv) begin
        res[31-8*r -: 8] = me[r] ^ mb[(r+1)%4] ^ md[(r+2)%4] ^ m9[(r+3)%4];
      end else begin
        res[31-8*r -: 8] = m2[r] ^ m3[(r+1)%4] ^ a[(r+2)%4] ^ a[(r+3)%4];
      end
    end
    return res;
  endfunction

  function automatic logic [127:0] mix_all(input logic [127:0] s, input logic inv);
    logic [127:0] res;
    for (int c = 0; c < 4; c++) begin
      res[127-32*c -: 32] = mix_col(s[127-32*c -: 32], inv);
    end
    return res;
  endfunction

  // SubBytes with ShiftRows, or their inverses; byte 4c+r sits at row r of column c.
  function automatic logic [127:0] sub_shift(input logic [127:0] s, input logic inv);
    logic [127:0] res;
    int src;
    for (int c = 0; c < 4; c++) begin
      for (int r = 0; r < 4; r++) begin
        src = inv ? ((c + 4 - r) % 4) : ((c + r) % 4);
        if (inv) begin
          res[127-8*(4*c+r) -: 8] = INV_SBOX[s[127-8*(4*src+r) -: 8]];
        end else begin
          res[127-8*(4*c+r) -: 8] = SBOX[s[127-8*(4*src+r) -: 8]];
        end
      end
    end
    return res;
  endfunction

  // Next four round-key words from the previous four.
  function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rcon);
    logic [31:0] w3;
    logic [31:0] t;
    logic [31:0] n0;
    logic [31:0] n1;
    logic [31:0] n2;
    logic [31:0] n3;
    w3 = k[31:0];
    t  = {SBOX[w3[23:16]], SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
    t  = t ^ {rcon, 24'h000000};
    n0 = k[127:96] ^ t;
    n1 = k[95:64] ^ n0;
    n2 = k[63:32] ^ n1;
    n3 = k[31:0] ^ n2;
    return {n0, n1, n2, n3};
  endfunction

endpackage

[hdl/aes128_if.sv]
// Valid/ready channel interfaces for the cipher's request and result streams.
interface aes128_in_if;
  logic        valid;
  logic        ready;
  logic        command;
  logic [63:0] block_high;
  logic [63:0] block_low;
  modport source (output valid, command, block_high, block_low, input ready);
  modport sink (input valid, command, block_high, block_low, output ready);
endinterface

interface aes128_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_high;
  logic [63:0] result_low;
  modport source (output valid, result_high, result_low, input ready);
  modport sink (input valid, result_high, result_low, output ready);
endinterface

[hdl/aes128_block_cipher_unit.sv]
// Top level of the AES-128 ECB cipher: controller, datapath and channel glue.
//
// Usage: write the key as two 64-bit halves through the configuration port,
// cfg_index 0 for key bytes 0 to 7 and 1 for bytes 8 to 15. Every write starts
// a key expansion that builds the encryption and decryption round keys,
// one round row per cycle; in_ch.ready stays low meanwhile.
// Requests arrive on in_ch with a command (0 encrypt, 1 decrypt) and the block
// as two halves; results leave on out_ch. A request takes a key-add step and
// then ten cipher rounds through the single shared round unit, so a new request
// is taken only after the previous one has finished its last round.
// The result sits in an output register, so the next request is accepted
// while an earlier result still waits. If the receiver stalls, the
// following request holds before its last round until the register frees.
// Reset is synchronous and active low; it clears the key to zero and runs the
// expansion of the all-zero key before the first request is taken.
module aes128_block_cipher_unit (
  input  logic                             clk,
  input  logic                             rst_n,
  aes128_in_if.sink                        in_ch,
  aes128_out_if.source                     out_ch,
  input  logic                             cfg_we,
  input  logic [aes128_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [aes128_pkg::CFG_W-1:0]     cfg_data
);
  import aes128_pkg::*;

  `include "assert_macros.svh"

  dp_cmd_t cmd;

  aes128_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .cmd       (cmd)
  );

  aes128_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_command      (in_ch.command),
    .in_block_high   (in_ch.block_high),
    .in_block_low    (in_ch.block_low),
    .cmd             (cmd),
    .out_result_high (out_ch.result_high),
    .out_result_low  (out_ch.result_low)
  );

  `ASSERT_NEXT(a_busy_after_accept, in_ch.valid && in_ch.ready, !in_ch.ready)
  `ASSERT_NEXT(a_key_write_blocks, cfg_we, !in_ch.ready)
  `ASSERT_SAME(a_result_slot_free, cmd.load_result, !out_ch.valid || out_ch.ready)
  `ASSERT_NEXT(a_result_shown, cmd.load_result, out_ch.valid)

endmodule

[hdl/aes128_ctrl.sv]
// Controller state machine sequencing key expansion and the cipher rounds.
module aes128_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output aes128_pkg::dp_cmd_t cmd
);
  import aes128_pkg::*;

  localparam logic [RA_W-1:0] LAST = RA_W'(NR);

  ctl_state_t      state_r, state_nxt;
  logic [RA_W-1:0] cnt_r, cnt_nxt;
  logic            out_valid_r, out_valid_nxt;
  logic            out_free;

  assign out_free = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    if (cfg_we) begin
      // A key write always restarts the expansion from the stored key.
      state_nxt = ST_EXP_LOAD;
      cnt_nxt   = '0;
    end else begin
      case (state_r)
        ST_EXP_LOAD: begin
          state_nxt = ST_EXPAND;
          cnt_nxt   = '0;
        end
        ST_EXPAND: begin
          if (cnt_r == LAST) begin
            state_nxt = ST_IDLE;
            cnt_nxt   = '0;
          end else begin
            cnt_nxt = cnt_r + 1'b1;
          end
        end
        ST_IDLE: begin
          if (in_valid) begin
            state_nxt = ST_ADD;
          end
        end
        ST_ADD: begin
          state_nxt = ST_ROUND;
          cnt_nxt   = RA_W'(1);
        end
        ST_ROUND: begin
          if (cnt_r != LAST) begin
            cnt_nxt = cnt_r + 1'b1;
          end else if (out_free) begin
            state_nxt = ST_IDLE;
            cnt_nxt   = '0;
          end
        end
        default: begin
          state_nxt = ST_EXP_LOAD;
          cnt_nxt   = '0;
        end
      endcase
    end
  end

  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    cmd.exp_addr = cnt_r;
    cmd.last    = (cnt_r == LAST);
    case (state_r)
      ST_EXP_LOAD: cmd.exp_load = 1'b1;
      ST_EXPAND:   cmd.exp_step = 1'b1;
      ST_IDLE: begin
        in_ready   = 1'b1;
        cmd.accept = in_valid;
      end
      ST_ADD: begin
        cmd.add_key = 1'b1;
        cmd.rd_addr = RA_W'(1);
      end
      ST_ROUND: begin
        // The final round waits here until the result register is free.
        cmd.rd_addr     = (cnt_r == LAST) ? LAST : cnt_r + 1'b1;
        cmd.do_round    = (cnt_r != LAST) || out_free;
        cmd.load_result = (cnt_r == LAST) && out_free;
      end
      default: cmd = '0;
    endcase
  end

  always_comb begin
    if (cmd.load_result) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_EXP_LOAD;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

[hdl/aes128_dp.sv]
// Datapath: key registers, round-key memories, key schedule and the round unit.
module aes128_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [aes128_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [aes128_pkg::CFG_W-1:0]         cfg_data,
  input  logic                                 in_command,
  input  logic [63:0]                          in_block_high,
  input  logic [63:0]                          in_block_low,
  input  aes128_pkg::dp_cmd_t                  cmd,
  output logic [63:0]                          out_result_high,
  output logic [63:0]                          out_result_low
);
  import aes128_pkg::*;

  localparam logic [RA_W-1:0] LAST = RA_W'(NR);

  logic [63:0]  key_high_r;
  logic [63:0]  key_low_r;
  logic [127:0] kr_r;
  logic [7:0]   rcon_r;
  logic [127:0] enc_mem [NROWS];
  logic [127:0] dec_mem [NROWS];
  logic [127:0] enc_rk_r;
  logic [127:0] dec_rk_r;
  logic [127:0] st_r;
  logic         dec_r;
  logic [127:0] result_r;
  logic [127:0] rk;
  logic [127:0] round_out;
  logic [127:0] subbed;
  logic [127:0] dec_row;
  logic [RA_W-1:0] dec_addr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_KEY_HIGH: key_high_r <= cfg_data;
        REG_KEY_LOW:  key_low_r  <= cfg_data;
        default:      key_low_r  <= key_low_r;
      endcase
    end
  end

  // Decryption rows run in reverse order; the middle ones go through InvMixColumns.
  assign dec_addr = LAST - cmd.exp_addr;
  assign dec_row  = (cmd.exp_addr == '0 || cmd.exp_addr == LAST) ? kr_r : mix_all(kr_r, 1'b1);

  always_ff @(posedge clk) begin
    if (cmd.exp_load) begin
      kr_r   <= {key_high_r, key_low_r};
      rcon_r <= 8'h01;
    end else if (cmd.exp_step) begin
      kr_r   <= key_next(kr_r, rcon_r);
      rcon_r <= xtime(rcon_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exp_step) begin
      enc_mem[cmd.exp_addr] <= kr_r;
      dec_mem[dec_addr]     <= dec_row;
    end
    enc_rk_r <= enc_mem[cmd.rd_addr];
    dec_rk_r <= dec_mem[cmd.rd_addr];
  end

  assign rk        = (dec_r == CMD_DECRYPT) ? dec_rk_r : enc_rk_r;
  assign subbed    = sub_shift(st_r, dec_r);
  assign round_out = (cmd.last ? subbed : mix_all(subbed, dec_r)) ^ rk;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      st_r  <= {in_block_high, in_block_low};
      dec_r <= in_command;
    end else if (cmd.add_key) begin
      st_r <= st_r ^ rk;
    end else if (cmd.do_round) begin
      st_r <= round_out;
    end
    if (cmd.load_result) begin
      result_r <= round_out;
    end
  end

  assign out_result_high = result_r[127:64];
  assign out_result_low  = result_r[63:0];

endmodule

[verif/aes128_block_cipher_unit_tb.sv]
// Self-checking testbench for the AES-128 ECB cipher unit, with its own cipher predictor.
module aes128_block_cipher_unit_tb;
  import aes128_pkg::*;

  localparam logic CMD_ENCRYPT = 1'b0;
  localparam int   LIMIT_CYCLES = 2000000;
  localparam int   DRAIN_CYCLES = 40;
  localparam int   RANDOM_PHASES = 8;
  localparam int   ITEMS_PER_PHASE = 155;

  typedef struct packed {
    logic [1:0]   rekey;     // bit 0 writes key_high, bit 1 writes key_low
    logic [63:0]  key_high;
    logic [63:0]  key_low;
    logic         command;
    logic [127:0] block;
    logic         typed;
    logic [127:0] result;
  } dir_row_t;

  localparam int DIR_ROWS = 12;
  localparam logic [127:0] ONES = {128{1'b1}};

  dir_row_t dir_rows [DIR_ROWS] = '{
    '{2'b00, 64'h0, 64'h0, CMD_ENCRYPT, 128'h0, 1'b1,
      128'h66e94bd4ef8a2c3b884cfa59ca342b2e},
    '{2'b00, 64'h0, 64'h0, CMD_DECRYPT, 128'h66e94bd4ef8a2c3b884cfa59ca342b2e, 1'b1,
      128'h0},
    '{2'b00, 64'h0, 64'h0, CMD_ENCRYPT, ONES, 1'b0, 128'h0},
    '{2'b00, 64'h0, 64'h0, CMD_DECRYPT, ONES, 1'b0, 128'h0},
    '{2'b00, 64'h0, 64'h0, CMD_ENCRYPT, {1'b1, 127'h0}, 1'b0, 128'h0},
    '{2'b11, 64'h0001020304050607, 64'h08090a0b0c0d0e0f, CMD_ENCRYPT,
      128'h00112233445566778899aabbccddeeff, 1'b1, 128'h69c4e0d86a7b0430d8cdb78070b4c55a},
    '{2'b00, 64'h0, 64'h0, CMD_DECRYPT, 128'h69c4e0d86a7b0430d8cdb78070b4c55a, 1'b1,
      128'h00112233445566778899aabbccddeeff},
    '{2'b11, {64{1'b1}}, {64{1'b1}}, CMD_ENCRYPT, 128'h0, 1'b0, 128'h0},
    '{2'b00, 64'h0, 64'h0, CMD_DECRYPT, ONES, 1'b0, 128'h0},
    // Only the low half changes; the high half keeps its all-ones value.
    '{2'b10, 64'h0, 64'h0, CMD_ENCRYPT, 128'h1, 1'b0, 128'h0},
    '{2'b01, 64'h0123456789abcdef, 64'h0, CMD_DECRYPT, 128'h1, 1'b0, 128'h0},
    '{2'b00, 64'h0, 64'h0, CMD_ENCRYPT, ONES, 1'b0, 128'h0}
  };

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  aes128_in_if  in_ch ();
  aes128_out_if out_ch ();

  aes128_block_cipher_unit i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Predictor state: current key and both round-key schedules.
  logic [63:0]  model_key_high;
  logic [63:0]  model_key_low;
  logic [31:0]  enc_keys [44];
  logic [31:0]  dec_keys [44];

  logic [127:0] expected_blocks [$];
  int           errors;
  int           results_checked;
  int           cycle_count;
  int           sender_idle_pct;
  int           receiver_stall_pct;
  logic         hold_request;

  function automatic logic [7:0] gf_times(logic [7:0] a, logic [7:0] b);
    logic [7:0] p;
    p = 8'h00;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) p = p ^ a;
      a = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    end
    return p;
  endfunction

  function automatic logic [31:0] column_mix(logic [31:0] w, logic inv);
    logic [7:0] coef [4];
    logic [7:0] acc;
    logic [31:0] res;
    if (inv) coef = '{8'd14, 8'd11, 8'd13, 8'd9};
    else coef = '{8'd2, 8'd3, 8'd1, 8'd1};
    for (int r = 0; r < 4; r++) begin
      acc = 8'h00;
      for (int k = 0; k < 4; k++) acc = acc ^ gf_times(coef[(k - r) & 3], w[31-8*k -: 8]);
      res[31-8*r -: 8] = acc;
    end
    return res;
  endfunction

  function automatic void expand_schedule();
    logic [31:0] t;
    logic [7:0] rcon;
    rcon = 8'h01;
    enc_keys[0] = model_key_high[63:32];
    enc_keys[1] = model_key_high[31:0];
    enc_keys[2] = model_key_low[63:32];
    enc_keys[3] = model_key_low[31:0];
    for (int i = 4; i < 44; i++) begin
      t = enc_keys[i-1];
      if (i % 4 == 0) begin
        t = {SBOX[t[23:16]], SBOX[t[15:8]], SBOX[t[7:0]], SBOX[t[31:24]]} ^ {rcon, 24'h0};
        rcon = gf_times(rcon, 8'h02);
      end
      enc_keys[i] = enc_keys[i-4] ^ t;
    end
    for (int r = 0; r <= NR; r++) begin
      for (int k = 0; k < 4; k++) begin
        t = enc_keys[4*(NR - r) + k];
        if (r != 0 && r != NR) t = column_mix(t, 1'b1);
        dec_keys[4*r + k] = t;
      end
    end
  endfunction

  function automatic logic [127:0] round_keys(logic dec, int round);
    if (dec) return {dec_keys[4*round], dec_keys[4*round+1], dec_keys[4*round+2],
                     dec_keys[4*round+3]};
    return {enc_keys[4*round], enc_keys[4*round+1], enc_keys[4*round+2], enc_keys[4*round+3]};
  endfunction

  // Byte 4c+r of the state is row r of column c; byte 0 is the top byte.
  function automatic logic [127:0] cipher_block(logic dec, logic [127:0] blk);
    logic [127:0] s;
    logic [127:0] tmp;
    int src;
    s = blk ^ round_keys(dec, 0);
    for (int round = 1; round <= NR; round++) begin
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          src = dec ? ((c + 4 - r) % 4) : ((c + r) % 4);
          tmp[127-8*(4*c+r) -: 8] = dec ? INV_SBOX[s[127-8*(4*src+r) -: 8]]
                                        : SBOX[s[127-8*(4*src+r) -: 8]];
        end
      end
      s = tmp;
      if (round != NR) begin
        for (int c = 0; c < 4; c++) s[127-32*c -: 32] = column_mix(s[127-32*c -: 32], dec);
      end
      s = s ^ round_keys(dec, round);
    end
    return s;
  endfunction

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.", cycle_count,
               expected_blocks.size());
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin : receiver
    int hold_left;
    hold_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request) begin
        hold_left = 400;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready = 1'b0;
      end else begin
        out_ch.ready = ($urandom_range(99) >= receiver_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    logic [127:0] want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_blocks.size() == 0) begin
        $error("result with none expected: %h_%h", out_ch.result_high, out_ch.result_low);
        errors++;
      end else begin
        want = expected_blocks.pop_front();
        results_checked++;
        if (out_ch.result_high !== want[127:64]) begin
          $error("result_high: expected %h, actual %h", want[127:64], out_ch.result_high);
          errors++;
        end
        if (out_ch.result_low !== want[63:0]) begin
          $error("result_low: expected %h, actual %h", want[63:0], out_ch.result_low);
          errors++;
        end
      end
    end
  end

  task automatic write_key_reg(logic [CFG_IDX_W-1:0] idx, logic [63:0] value);
    cfg_we = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_we = 1'b0;
    if (idx == REG_KEY_HIGH) model_key_high = value;
    else model_key_low = value;
    expand_schedule();
  endtask

  // Offers one request and returns once it has been taken; called at a falling edge.
  task automatic send_request(logic cmd, logic [127:0] blk, output logic [127:0] want);
    while ($urandom_range(99) < sender_idle_pct) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.valid = 1'b1;
    in_ch.command = cmd;
    in_ch.block_high = blk[127:64];
    in_ch.block_low = blk[63:0];
    do @(posedge clk); while (!in_ch.ready);
    want = cipher_block(cmd, blk);
    expected_blocks.push_back(want);
    @(negedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid = 1'b0;
    while (expected_blocks.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  initial begin : stimulus
    logic [127:0] want;
    logic [63:0] kh;
    logic [63:0] kl;
    int pick;
    errors = 0;
    results_checked = 0;
    cycle_count = 0;
    hold_request = 1'b0;
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_KEY_HIGH;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.command = CMD_ENCRYPT;
    in_ch.block_high = '0;
    in_ch.block_low = '0;
    model_key_high = '0;
    model_key_low = '0;
    expand_schedule();
    repeat (7) @(negedge clk);
    rst_n = 1'b1;

    for (int i = 0; i < DIR_ROWS; i++) begin
      if (dir_rows[i].rekey != 2'b00) begin
        wait_drained();
        if (dir_rows[i].rekey[0]) write_key_reg(REG_KEY_HIGH, dir_rows[i].key_high);
        if (dir_rows[i].rekey[1]) write_key_reg(REG_KEY_LOW, dir_rows[i].key_low);
      end
      send_request(dir_rows[i].command, dir_rows[i].block, want);
      if (dir_rows[i].typed && want !== dir_rows[i].result) begin
        $error("row %0d prediction: expected %h, actual %h", i, dir_rows[i].result, want);
        errors++;
      end
    end

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_drained();
      case (phase % 4)
        0: begin sender_idle_pct = 0;  receiver_stall_pct = 0;  end
        1: begin sender_idle_pct = 64; receiver_stall_pct = 0;  end
        2: begin sender_idle_pct = 0;  receiver_stall_pct = 64; end
        default: begin sender_idle_pct = 19; receiver_stall_pct = 19; end
      endcase
      kh = {$urandom, $urandom};
      kl = {$urandom, $urandom};
      pick = $urandom_range(3);
      if (phase == RANDOM_PHASES - 1) begin
        kh = '1;
        kl = '1;
      end else if (phase == 3) begin
        kh = '0;
        kl = '0;
      end
      case (pick)
        0: write_key_reg(REG_KEY_HIGH, kh);
        1: write_key_reg(REG_KEY_LOW, kl);
        default: begin
          write_key_reg(REG_KEY_HIGH, kh);
          write_key_reg(REG_KEY_LOW, kl);
        end
      endcase
      if (phase == 0) hold_request = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        send_request(1'($urandom_range(1)), {$urandom, $urandom, $urandom, $urandom}, want);
      end
    end
    wait_drained();

    $display("Checked %0d cipher results over directed vectors and %0d random key phases,",
             results_checked, RANDOM_PHASES);
    $display("with encrypt and decrypt mixed under sender gaps and receiver back-pressure.");
    if (errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+hdl
hdl/aes128_pkg.sv
hdl/aes128_if.sv
hdl/aes128_ctrl.sv
hdl/aes128_dp.sv
hdl/aes128_block_cipher_unit.sv
verif/aes128_block_cipher_unit_tb.sv
